// ----- rtl/sca_pkg.sv -----
// Shared types and constants for the sector cache age replacement engine.
package sca_pkg;

    localparam int TAG_W     = 32;
    localparam int AGE_W     = 32;
    localparam int WAY_OUT_W = 6;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE
    } t_state;

endpackage

// ----- rtl/sca_if.sv -----
// Request and response channel interfaces of the sector cache engine.
interface sca_req_if;
    import sca_pkg::*;

    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] sector_number;

    modport source (output valid, output sector_number, input ready);
    modport sink (input valid, input sector_number, output ready);
endinterface

interface sca_rsp_if;
    import sca_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_index;

    modport source (output valid, output hit, output way_index, input ready);
    modport sink (input valid, input hit, input way_index, output ready);
endinterface

// ----- rtl/sca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sector_cache_age_replacement_top.sv -----
// Sector cache tag search and age-based replacement engine, top level.
// One request at a time: a scan pass reads every way from the tag and age RAMs,
// the response word is loaded once the output register is free, then an age
// update pass rewrites every age; a new request is accepted only back in idle.
// Reset: synchronous; per-way valid flops make every tag and age read as zero.
module sector_cache_age_replacement_top #(
    parameter int NUM_WAYS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sca_req_if.sink   i_req,
    sca_rsp_if.source o_rsp
);
    import sca_pkg::*;

    localparam int IDX_W = $clog2(NUM_WAYS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WAYS - 1);

    t_state r_state, n_state;

    // Read sequencer and data stage
    logic [IDX_W-1:0] r_idx;
    logic             r_issue;
    logic             r_p_vld;
    logic             r_p_last;
    logic [IDX_W-1:0] r_p_idx;
    logic             r_p_tvld;
    logic             r_p_avld;

    // Request context
    logic [TAG_W-1:0] r_sector;
    logic             r_found;
    logic [IDX_W-1:0] r_match;
    logic [AGE_W-1:0] r_best_age;
    logic [IDX_W-1:0] r_best_idx;
    logic [IDX_W-1:0] r_chosen;

    logic [NUM_WAYS-1:0] r_tag_vld;
    logic [NUM_WAYS-1:0] r_age_vld;

    // Output register
    logic                 r_out_vld;
    logic                 r_out_hit;
    logic [WAY_OUT_W-1:0] r_out_way;

    logic             req_ready;
    logic             start_scan;
    logic             start_age;
    logic             tag_we;
    logic             age_we;
    logic             out_free;
    logic [TAG_W-1:0] tag_rd;
    logic [AGE_W-1:0] age_rd;
    logic [TAG_W-1:0] tag_cur;
    logic [AGE_W-1:0] age_cur;
    logic [AGE_W-1:0] age_new;
    logic [IDX_W-1:0] n_chosen;
    logic [IDX_W+WAY_OUT_W-1:0] way_ext;

    sca_ram #(.WIDTH(TAG_W), .DEPTH(NUM_WAYS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_best_idx),
        .i_wdata (r_sector),
        .i_raddr (r_idx),
        .o_rdata (tag_rd)
    );

    sca_ram #(.WIDTH(AGE_W), .DEPTH(NUM_WAYS)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (r_p_idx),
        .i_wdata (age_new),
        .i_raddr (r_idx),
        .o_rdata (age_rd)
    );

    // Mask entries never written since reset
    assign tag_cur = r_p_tvld ? tag_rd : '0;
    assign age_cur = r_p_avld ? age_rd : '0;

    assign out_free = !r_out_vld || o_rsp.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_req.valid) n_state = ST_SCAN;
            ST_SCAN:   if (r_p_vld && r_p_last) n_state = ST_DECIDE;
            ST_DECIDE: if (out_free) n_state = ST_AGE;
            ST_AGE:    if (r_p_vld && r_p_last) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        req_ready = 1'b0;
        start_age = 1'b0;
        age_we    = 1'b0;
        case (r_state)
            ST_IDLE:   req_ready = 1'b1;
            ST_SCAN:   ;
            ST_DECIDE: start_age = out_free;
            ST_AGE:    age_we = r_p_vld;
            default:   ;
        endcase
    end

    assign start_scan = i_req.valid && req_ready;
    assign tag_we     = start_age && !r_found;
    assign n_chosen   = r_found ? r_match : r_best_idx;
    assign way_ext    = {WAY_OUT_W'(0), n_chosen};

    // Clear the chosen way, bump every other age with saturation
    always_comb begin
        if (r_p_idx == r_chosen) begin
            age_new = '0;
        end else if (age_cur == AGE_MAX) begin
            age_new = AGE_MAX;
        end else begin
            age_new = age_cur + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk the ways, one read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            if (start_scan || start_age) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_idx == LAST_IDX)) begin
                r_issue <= 1'b0;
            end
            r_p_vld <= r_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_scan || start_age) begin
            r_idx <= '0;
        end else if (r_issue) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_p_last <= (r_idx == LAST_IDX);
        r_p_idx  <= r_idx;
        r_p_tvld <= r_tag_vld[r_idx];
        r_p_avld <= r_age_vld[r_idx];
    end

    // Track the first tag match and the oldest way, lowest index on ties
    always_ff @(posedge i_clk) begin
        if (start_scan) begin
            r_sector <= i_req.sector_number;
            r_found  <= 1'b0;
        end else if ((r_state == ST_SCAN) && r_p_vld) begin
            if (!r_found && (tag_cur == r_sector)) begin
                r_found <= 1'b1;
                r_match <= r_p_idx;
            end
            if ((r_p_idx == '0) || (age_cur > r_best_age)) begin
                r_best_age <= age_cur;
                r_best_idx <= r_p_idx;
            end
        end
        if (start_age) begin
            r_chosen <= n_chosen;
        end
    end

    // Valid flops for entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= '0;
            r_age_vld <= '0;
        end else begin
            if (tag_we) begin
                r_tag_vld[r_best_idx] <= 1'b1;
            end
            if (age_we) begin
                r_age_vld[r_p_idx] <= 1'b1;
            end
        end
    end

    // Output register: load the response word, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (start_age) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_age) begin
            r_out_hit <= r_found;
            r_out_way <= way_ext[WAY_OUT_W-1:0];
        end
    end

    assign i_req.ready     = req_ready;
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.hit       = r_out_hit;
    assign o_rsp.way_index = r_out_way;
endmodule

// ----- rtl/sca_checker.sv -----
// Port-level checks for the sector cache engine, bound to the top level.
module sca_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic                          i_rsp_hit,
    input logic [sca_pkg::WAY_OUT_W-1:0] i_rsp_way
);
    import sca_pkg::*;

    // Response word holds while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_way)))
        else $error("response word changed while stalled");

    // One request in flight: no back-to-back accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while previous still in work");

    // A new response word is never raised while the engine is idle
    a_rsp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !i_req_ready)
        else $error("response raised while engine idle");

    // Reset drops the response
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");
endmodule

bind sector_cache_age_replacement_top sca_checker u_sca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_hit   (o_rsp.hit),
    .i_rsp_way   (o_rsp.way_index)
);

// ----- tb/tb_sector_cache_age_replacement_top.sv -----
// Self-checking testbench for the sector cache age replacement engine.
module tb_sector_cache_age_replacement_top;
    import sca_pkg::*;

    localparam int NUM_WAYS    = 64;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYC  = 2 * NUM_WAYS + 8;

    typedef struct {
        logic [TAG_W-1:0]     sector;
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_index;
    } t_lookup_result;

    logic i_clk;
    logic i_rst_n;

    sca_req_if req_ch ();
    sca_rsp_if rsp_ch ();

    sector_cache_age_replacement_top #(
        .NUM_WAYS(NUM_WAYS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Shadow copy of the tag and age RAMs
    logic [TAG_W-1:0] cache_tags[NUM_WAYS];
    logic [AGE_W-1:0] way_ages[NUM_WAYS];

    t_lookup_result   pending_lookups[$];
    logic [TAG_W-1:0] hot_pool[$];
    logic [TAG_W-1:0] wide_pool[$];

    int unsigned sent_total  = 0;
    int unsigned hit_total   = 0;
    int unsigned miss_total  = 0;
    int unsigned evict_total = 0;
    int unsigned matched     = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    bit          calm        = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Search the tags, refill the oldest way on a miss, then age every way
    function automatic t_lookup_result predict_lookup(input logic [TAG_W-1:0] sector);
        t_lookup_result res;
        int unsigned    pick;
        bit             found;
        found = 1'b0;
        pick  = 0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && cache_tags[w] == sector) begin
                found = 1'b1;
                pick  = w;
            end
        end
        if (!found) begin
            // Greatest age wins, lowest index on a tie
            for (int w = 1; w < NUM_WAYS; w++) begin
                if (way_ages[w] > way_ages[pick]) pick = w;
            end
            if (cache_tags[pick] != '0) evict_total++;
            cache_tags[pick] = sector;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w == pick) way_ages[w] = '0;
            else if (way_ages[w] != AGE_MAX) way_ages[w] = way_ages[w] + 1'b1;
        end
        res.sector    = sector;
        res.hit       = found;
        res.way_index = WAY_OUT_W'(pick);
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR @%0d: %s", cycle_count, msg);
    endfunction

    function automatic logic [TAG_W-1:0] random_sector();
        logic [TAG_W-1:0] v;
        do v = $urandom(); while (v == '0);
        return v;
    endfunction

    // Mostly back to back, with an occasional idle gap before a request
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 94) return $urandom_range(1, 4);
        return $urandom_range(100, 220);
    endfunction

    function automatic int unsigned receiver_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 97) return $urandom_range(1, 4);
        return $urandom_range(20, 140);
    endfunction

    // Present one request word and hold it until accepted
    task automatic send_sector(input logic [TAG_W-1:0] sector);
        t_lookup_result res;
        int unsigned    gap;
        gap = sender_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.sector_number = sector;
        do @(posedge i_clk); while (!req_ch.ready);
        res = predict_lookup(sector);
        pending_lookups.push_back(res);
        sent_total++;
        if (res.hit) hit_total++;
        else miss_total++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected response word has come back
    task automatic wait_for_results();
        req_ch.valid = 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Extremes of the sector field, sector zero and the empty-way duplicates
    task automatic test_directed();
        calm = 1'b0;
        // Sector zero matches every empty way, so the lowest one must win
        send_sector('0);
        send_sector('0);
        send_sector(32'h0000_0001);
        send_sector('1);
        send_sector(32'hAAAA_AAAA);
        send_sector(32'h5555_5555);
        send_sector(32'h8000_0000);
        send_sector(32'h0000_0001);
        send_sector('1);
        send_sector('0);
        send_sector(32'h7FFF_FFFF);
        send_sector(32'hAAAA_AAAA);
        send_sector(32'h8000_0000);
        send_sector(32'h0000_0002);
    endtask

    // Fill every way, then wrap around so the oldest entries get evicted
    task automatic test_fill_sweep();
        calm = 1'b1;
        for (int i = 0; i < NUM_WAYS + 6; i++) send_sector(32'h0001_0000 + i);
        for (int i = 0; i < 10; i++) send_sector(32'h0001_0000 + i);
        calm = 1'b0;
    endtask

    // Small working set: nearly all hits once warm
    task automatic test_hot_set();
        hot_pool.delete();
        for (int i = 0; i < 12; i++) hot_pool.push_back(random_sector());
        for (int i = 0; i < 150; i++) send_sector(hot_pool[$urandom_range(0, 11)]);
    endtask

    // Working set a bit larger than the cache: mix of hits and evictions
    task automatic test_thrash();
        wide_pool.delete();
        for (int i = 0; i < 80; i++) wide_pool.push_back(random_sector());
        for (int i = 0; i < 200; i++) begin
            if (i == 60) calm = 1'b1;
            if (i == 110) calm = 1'b0;
            send_sector(wide_pool[$urandom_range(0, 79)]);
        end
    endtask

    // Unrelated sectors: all misses, every bit of the field toggles
    task automatic test_random_sectors();
        for (int i = 0; i < 80; i++) send_sector($urandom());
    endtask

    // Blend of all traffic shapes, with one full drain in the middle
    task automatic test_mixed();
        int unsigned r;
        for (int i = 0; i < 190; i++) begin
            if (i == 95) wait_for_results();
            if (i % 40 == 0) calm = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 50) send_sector(hot_pool[$urandom_range(0, 11)]);
            else if (r < 85) send_sector(wide_pool[$urandom_range(0, 79)]);
            else if (r < 98) send_sector($urandom());
            else send_sector('0);
        end
        calm = 1'b0;
    endtask

    // Response side: random backpressure unless in a calm stretch
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end else begin
            rsp_ch.ready = 1'b1;
            if (!calm) stall_left = receiver_stall();
        end
    end

    // Compare each response word with the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lookups.size() == 0) begin
                note_failure($sformatf("unexpected response hit=%0b way=%0d",
                    rsp_ch.hit, rsp_ch.way_index));
            end else begin
                want = pending_lookups.pop_front();
                if (rsp_ch.hit !== want.hit || rsp_ch.way_index !== want.way_index) begin
                    note_failure($sformatf(
                        "sector %08h: expected hit=%0b way=%0d, got hit=%0b way=%0d",
                        want.sector, want.hit, want.way_index,
                        rsp_ch.hit, rsp_ch.way_index));
                end else begin
                    matched++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                CYCLE_LIMIT, pending_lookups.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sequence
    initial begin
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.sector_number = '0;
        rsp_ch.ready         = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            cache_tags[w] = '0;
            way_ages[w]   = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill_sweep();
        test_hot_set();
        test_thrash();
        test_random_sectors();
        test_mixed();

        wait_for_results();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("lookups: %0d sent, %0d hits, %0d misses, %0d evictions of filled ways",
            sent_total, hit_total, miss_total, evict_total);
        $display("responses: %0d matched, %0d failures", matched, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sector_cache_age_replacement_top.f -----
rtl/sca_pkg.sv
rtl/sca_if.sv
rtl/sca_ram.sv
rtl/sector_cache_age_replacement_top.sv
rtl/sca_checker.sv
tb/tb_sector_cache_age_replacement_top.sv
